// ===== hdl/ptb_pkg.sv =====
// Shared types, widths and codes for the per-address token bucket unit.
// No dependencies; every other file depends on this package.
package ptb_pkg;

    localparam int TABLE_ENTRIES = 64;
    localparam int IDX_W         = $clog2(TABLE_ENTRIES);
    localparam int ADDR_W        = 64;
    localparam int TOK_W         = 16;
    localparam int NPT_W         = 32;
    localparam int TIME_W        = 63;
    localparam int STAT_W        = 3;
    localparam int DIV_STEPS     = TIME_W;
    localparam int STEP_W        = $clog2(DIV_STEPS);
    localparam int CFG_IDX_W     = 1;
    localparam int CFG_DATA_W    = 32;

    localparam logic [CFG_IDX_W-1:0] CFG_BURST = 1'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_NPT   = 1'd1;

    localparam logic [TOK_W-1:0] BURST_RESET = 16'd5;
    localparam logic [NPT_W-1:0] NPT_RESET   = 32'd1000000000;

    localparam logic [STAT_W-1:0] ST_REFILLED = 3'd0;
    localparam logic [STAT_W-1:0] ST_CREATED  = 3'd1;
    localparam logic [STAT_W-1:0] ST_REMOVED  = 3'd2;
    localparam logic [STAT_W-1:0] ST_NOTFOUND = 3'd3;
    localparam logic [STAT_W-1:0] ST_FULL     = 3'd4;

    localparam logic OP_TRIGGER = 1'b0;
    localparam logic OP_REMOVE  = 1'b1;

    // datapath actions issued by the controller
    localparam int ACT_W = 4;
    localparam logic [ACT_W-1:0] ACT_NONE     = 4'd0;
    localparam logic [ACT_W-1:0] ACT_DEL      = 4'd1;
    localparam logic [ACT_W-1:0] ACT_NOTFOUND = 4'd2;
    localparam logic [ACT_W-1:0] ACT_INSERT   = 4'd3;
    localparam logic [ACT_W-1:0] ACT_FULL     = 4'd4;
    localparam logic [ACT_W-1:0] ACT_ZERO     = 4'd5;
    localparam logic [ACT_W-1:0] ACT_BURST    = 4'd6;
    localparam logic [ACT_W-1:0] ACT_DIVINIT  = 4'd7;
    localparam logic [ACT_W-1:0] ACT_APPLY    = 4'd8;

    typedef struct packed {
        logic              is_v6;
        logic [ADDR_W-1:0] key_high;
        logic [ADDR_W-1:0] key_low;
        logic [TOK_W-1:0]  tokens;
        logic [TIME_W-1:0] last;
    } t_entry;

    typedef struct packed {
        logic             load;
        logic             sweep;
        logic [ACT_W-1:0] act;
        logic             div_step;
        logic             out_load;
    } t_cmd;

    typedef struct packed {
        logic is_remove;
        logic sweep_done;
        logic hit;
        logic free_vld;
        logic time_back;
        logic npt_zero;
        logic div_last;
        logic out_free;
    } t_sts;

endpackage

// ===== hdl/ptb_in_if.sv =====
// Input channel: valid/ready plus one request word.
// Depends on ptb_pkg.
interface ptb_in_if;
    logic                         valid;
    logic                         ready;
    logic                         op;
    logic                         is_ipv6;
    logic [ptb_pkg::ADDR_W-1:0]   addr_high;
    logic [ptb_pkg::ADDR_W-1:0]   addr_low;
    logic [ptb_pkg::TIME_W-1:0]   now_ns;

    modport source (output valid, op, is_ipv6, addr_high, addr_low, now_ns, input ready);
    modport sink   (input valid, op, is_ipv6, addr_high, addr_low, now_ns, output ready);
endinterface

// ===== hdl/ptb_out_if.sv =====
// Output channel: valid/ready plus one result word.
// Depends on ptb_pkg.
interface ptb_out_if;
    logic                         valid;
    logic                         ready;
    logic [ptb_pkg::STAT_W-1:0]   status;
    logic [ptb_pkg::TOK_W-1:0]    tokens;

    modport source (output valid, status, tokens, input ready);
    modport sink   (input valid, status, tokens, output ready);
endinterface

// ===== hdl/per_address_token_bucket_unit.sv =====
// Per-address token bucket unit: request channel in, result channel out,
// plain configuration write port. Depends on ptb_pkg, ptb_in_if, ptb_out_if,
// ptb_ctrl and ptb_dp.
//
// Each request word on i_in (trigger or remove for one IPv4/IPv6 address)
// gives exactly one result word on o_out: status and token count.
// One request is worked at a time. Every request sweeps the whole entry
// table through its single read port, one entry a cycle. A refill of an
// existing entry then runs a bit-serial divide of elapsed time by
// ns_per_token, unless time went back or ns_per_token is zero.
// The result sits in an output register, so the next request is accepted
// while it waits; a stalled receiver holds the unit once a second result
// is ready. Reset clears all entry valid bits and restores burst_limit 5
// and ns_per_token 1e9; the table itself needs no clearing pass.
// Configuration writes are taken at any edge with i_cfg_we high; index 0
// is burst_limit, index 1 is ns_per_token.
module per_address_token_bucket_unit (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_cfg_we,
    input  logic [ptb_pkg::CFG_IDX_W-1:0]     i_cfg_idx,
    input  logic [ptb_pkg::CFG_DATA_W-1:0]    i_cfg_data,
    ptb_in_if.sink                            i_in,
    ptb_out_if.source                         o_out
);
    import ptb_pkg::*;

    t_cmd cmd;
    t_sts sts;
    logic in_ready;

    assign i_in.ready = in_ready;

    ptb_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in.valid),
        .o_in_ready (in_ready),
        .i_sts      (sts),
        .o_cmd      (cmd)
    );

    ptb_dp u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_idx   (i_cfg_idx),
        .i_cfg_data  (i_cfg_data),
        .i_op        (i_in.op),
        .i_is_ipv6   (i_in.is_ipv6),
        .i_addr_high (i_in.addr_high),
        .i_addr_low  (i_in.addr_low),
        .i_now_ns    (i_in.now_ns),
        .i_out_ready (o_out.ready),
        .o_out_valid (o_out.valid),
        .o_status    (o_out.status),
        .o_tokens    (o_out.tokens),
        .i_cmd       (cmd),
        .o_sts       (sts)
    );

endmodule

// ===== hdl/ptb_ctrl.sv =====
// Controller state machine for the token bucket unit.
// Depends on ptb_pkg; drives the datapath through t_cmd, watches t_sts.
module ptb_ctrl (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_in_valid,
    output logic           o_in_ready,
    input  ptb_pkg::t_sts  i_sts,
    output ptb_pkg::t_cmd  o_cmd
);
    import ptb_pkg::*;

    localparam logic [2:0] S_IDLE   = 3'd0;
    localparam logic [2:0] S_SWEEP  = 3'd1;
    localparam logic [2:0] S_DECIDE = 3'd2;
    localparam logic [2:0] S_DIV    = 3'd3;
    localparam logic [2:0] S_APPLY  = 3'd4;
    localparam logic [2:0] S_RESULT = 3'd5;

    logic [2:0] r_state, n_state;

    assign o_in_ready = (r_state == S_IDLE);

    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    o_cmd.load = 1'b1;
                    n_state    = S_SWEEP;
                end
            end
            S_SWEEP: begin
                o_cmd.sweep = 1'b1;
                if (i_sts.sweep_done) n_state = S_DECIDE;
            end
            S_DECIDE: begin
                n_state = S_RESULT;
                if (i_sts.is_remove) begin
                    o_cmd.act = i_sts.hit ? ACT_DEL : ACT_NOTFOUND;
                end else if (!i_sts.hit) begin
                    o_cmd.act = i_sts.free_vld ? ACT_INSERT : ACT_FULL;
                end else if (i_sts.time_back) begin
                    o_cmd.act = ACT_ZERO;
                end else if (i_sts.npt_zero) begin
                    o_cmd.act = ACT_BURST;
                end else begin
                    o_cmd.act = ACT_DIVINIT;
                    n_state   = S_DIV;
                end
            end
            S_DIV: begin
                o_cmd.div_step = 1'b1;
                if (i_sts.div_last) n_state = S_APPLY;
            end
            S_APPLY: begin
                o_cmd.act = ACT_APPLY;
                n_state   = S_RESULT;
            end
            S_RESULT: begin
                if (i_sts.out_free) begin
                    o_cmd.out_load = 1'b1;
                    n_state        = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r_state <= S_IDLE;
        else          r_state <= n_state;
    end

endmodule

// ===== hdl/ptb_dp.sv =====
// Datapath: entry memory, valid bits, table sweep, refill divider, result register.
// Depends on ptb_pkg; sequenced by ptb_ctrl.
module ptb_dp (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_cfg_we,
    input  logic [ptb_pkg::CFG_IDX_W-1:0]     i_cfg_idx,
    input  logic [ptb_pkg::CFG_DATA_W-1:0]    i_cfg_data,
    input  logic                              i_op,
    input  logic                              i_is_ipv6,
    input  logic [ptb_pkg::ADDR_W-1:0]        i_addr_high,
    input  logic [ptb_pkg::ADDR_W-1:0]        i_addr_low,
    input  logic [ptb_pkg::TIME_W-1:0]        i_now_ns,
    input  logic                              i_out_ready,
    output logic                              o_out_valid,
    output logic [ptb_pkg::STAT_W-1:0]        o_status,
    output logic [ptb_pkg::TOK_W-1:0]         o_tokens,
    input  ptb_pkg::t_cmd                     i_cmd,
    output ptb_pkg::t_sts                     o_sts
);
    import ptb_pkg::*;

    localparam logic [IDX_W-1:0]  LAST_IDX  = IDX_W'(TABLE_ENTRIES - 1);
    localparam logic [STEP_W-1:0] LAST_STEP = STEP_W'(DIV_STEPS - 1);

    logic [TOK_W-1:0]  r_burst;
    logic [NPT_W-1:0]  r_npt;

    // latched request
    logic              r_remove;
    logic              r_v6;
    logic [ADDR_W-1:0] r_hi, r_lo;
    logic [TIME_W-1:0] r_now;

    // table
    t_entry            r_mem [TABLE_ENTRIES];
    t_entry            r_rd;
    logic              r_valid [TABLE_ENTRIES];
    logic              mem_we;
    logic [IDX_W-1:0]  mem_wa;
    t_entry            mem_wd;

    // sweep
    logic [IDX_W-1:0]  r_cnt, r_rd_idx;
    logic              r_run, r_pend;
    logic              r_hit, r_free_vld;
    logic [IDX_W-1:0]  r_hit_idx, r_free_idx;
    logic [TOK_W-1:0]  r_tok;
    logic [TIME_W-1:0] r_last;
    logic              match;

    // divider
    logic [TIME_W-1:0] r_quo;
    logic [NPT_W-1:0]  r_rem;
    logic [STEP_W-1:0] r_step;
    logic [NPT_W:0]    rem_sh;
    logic              q_bit;

    // refill clamp
    logic [TOK_W-1:0]  room;
    logic              clamp;
    logic [TOK_W-1:0]  new_tok;

    logic [STAT_W-1:0] r_res_status;
    logic [TOK_W-1:0]  r_res_tok;
    logic              r_out_valid;
    logic [STAT_W-1:0] r_out_status;
    logic [TOK_W-1:0]  r_out_tok;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_burst <= BURST_RESET;
            r_npt   <= NPT_RESET;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                CFG_BURST: r_burst <= i_cfg_data[TOK_W-1:0];
                CFG_NPT:   r_npt   <= i_cfg_data[NPT_W-1:0];
                default:   ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_remove <= (i_op == OP_REMOVE);
            r_v6     <= i_is_ipv6;
            r_hi     <= i_is_ipv6 ? i_addr_high : '0;
            r_lo     <= i_is_ipv6 ? i_addr_low : {32'd0, i_addr_low[31:0]};
            r_now    <= i_now_ns;
        end
    end

    assign match = r_valid[r_rd_idx] && (r_rd.is_v6 == r_v6) &&
                   (r_rd.key_high == r_hi) && (r_rd.key_low == r_lo);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_run      <= 1'b0;
            r_pend     <= 1'b0;
            r_hit      <= 1'b0;
            r_free_vld <= 1'b0;
        end else if (i_cmd.load) begin
            r_run      <= 1'b1;
            r_pend     <= 1'b0;
            r_hit      <= 1'b0;
            r_free_vld <= 1'b0;
        end else if (i_cmd.sweep) begin
            r_pend <= r_run;
            if (r_run && r_cnt == LAST_IDX) r_run <= 1'b0;
            if (r_pend && match) r_hit <= 1'b1;
            if (r_pend && !r_valid[r_rd_idx] && !r_free_vld) r_free_vld <= 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_cnt <= '0;
        end else if (i_cmd.sweep) begin
            r_rd_idx <= r_cnt;
            if (r_run && r_cnt != LAST_IDX) r_cnt <= r_cnt + 1'b1;
            if (r_pend && match) begin
                r_hit_idx <= r_rd_idx;
                r_tok     <= r_rd.tokens;
                r_last    <= r_rd.last;
            end
            if (r_pend && !r_valid[r_rd_idx] && !r_free_vld) r_free_idx <= r_rd_idx;
        end
    end

    // restoring division of elapsed time by ns_per_token, one bit a cycle
    assign rem_sh = {r_rem, r_quo[TIME_W-1]};
    assign q_bit  = (rem_sh >= {1'b0, r_npt});

    always_ff @(posedge i_clk) begin
        if (i_cmd.act == ACT_DIVINIT) begin
            r_quo  <= r_now - r_last;
            r_rem  <= '0;
            r_step <= '0;
        end else if (i_cmd.div_step) begin
            r_quo  <= {r_quo[TIME_W-2:0], q_bit};
            r_rem  <= q_bit ? NPT_W'(rem_sh - {1'b0, r_npt}) : rem_sh[NPT_W-1:0];
            r_step <= r_step + 1'b1;
        end
    end

    assign room    = r_burst - r_tok;
    assign clamp   = (r_tok > r_burst) || (r_quo > {{(TIME_W-TOK_W){1'b0}}, room});
    assign new_tok = clamp ? r_burst : TOK_W'(r_tok + r_quo[TOK_W-1:0]);

    always_comb begin
        mem_we = 1'b0;
        mem_wa = r_hit_idx;
        mem_wd = '{is_v6: r_v6, key_high: r_hi, key_low: r_lo, tokens: r_tok, last: r_last};
        case (i_cmd.act)
            ACT_INSERT: begin
                mem_we        = 1'b1;
                mem_wa        = r_free_idx;
                mem_wd.tokens = r_burst;
                mem_wd.last   = r_now;
            end
            ACT_ZERO: begin
                mem_we        = 1'b1;
                mem_wd.tokens = '0;
            end
            ACT_BURST: begin
                mem_we        = 1'b1;
                mem_wd.tokens = r_burst;
            end
            ACT_APPLY: begin
                // last advances by quotient * ns_per_token, which is elapsed minus remainder
                mem_we        = 1'b1;
                mem_wd.tokens = new_tok;
                mem_wd.last   = r_now - TIME_W'(r_rem);
            end
            default: mem_we = 1'b0;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (mem_we) r_mem[mem_wa] <= mem_wd;
        r_rd <= r_mem[r_cnt];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int k = 0; k < TABLE_ENTRIES; k++) r_valid[k] <= 1'b0;
        end else if (i_cmd.act == ACT_DEL) begin
            r_valid[r_hit_idx] <= 1'b0;
        end else if (i_cmd.act == ACT_INSERT) begin
            r_valid[r_free_idx] <= 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        case (i_cmd.act)
            ACT_DEL:      begin r_res_status <= ST_REMOVED;  r_res_tok <= '0;      end
            ACT_NOTFOUND: begin r_res_status <= ST_NOTFOUND; r_res_tok <= '0;      end
            ACT_INSERT:   begin r_res_status <= ST_CREATED;  r_res_tok <= r_burst; end
            ACT_FULL:     begin r_res_status <= ST_FULL;     r_res_tok <= '0;      end
            ACT_ZERO:     begin r_res_status <= ST_REFILLED; r_res_tok <= '0;      end
            ACT_BURST:    begin r_res_status <= ST_REFILLED; r_res_tok <= r_burst; end
            ACT_APPLY:    begin r_res_status <= ST_REFILLED; r_res_tok <= new_tok; end
            default:      ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.out_load) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.out_load) begin
            r_out_status <= r_res_status;
            r_out_tok    <= r_res_tok;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_status    = r_out_status;
    assign o_tokens    = r_out_tok;

    assign o_sts.is_remove  = r_remove;
    assign o_sts.sweep_done = r_pend && (r_rd_idx == LAST_IDX);
    assign o_sts.hit        = r_hit;
    assign o_sts.free_vld   = r_free_vld;
    assign o_sts.time_back  = (r_now < r_last);
    assign o_sts.npt_zero   = (r_npt == '0);
    assign o_sts.div_last   = (r_step == LAST_STEP);
    assign o_sts.out_free   = !r_out_valid || i_out_ready;

endmodule
